// File: src/ctw_pkg.sv
// ----------------------------------------------------------------------------
// ctw_pkg
// Shared types, constants and helper functions of the text console writer.
// ----------------------------------------------------------------------------
package ctw_pkg;

    localparam int MAX_COLUMNS = 80;
    localparam int MAX_ROWS    = 25;
    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 2 * CHAR_W;
    localparam int CMD_W      = 3;
    localparam int CIDX_W     = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int PROD_W     = COL_W + ROW_W;

    localparam int TAB_STOP = 4;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
    localparam logic [CHAR_W-1:0] ATTR_DEFAULT = 8'h07;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT      = 3'd0,
        CMD_CLEAR    = 3'd1,
        CMD_SET_ATTR = 3'd2,
        CMD_SCROLL   = 3'd3,
        CMD_READ     = 3'd4
    } t_command;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLR,
        ST_SETUP,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_EXEC,
        OP_SWEEP,
        OP_SCR_SETUP,
        OP_SCR_RD,
        OP_SCR_WR,
        OP_RD_CAP
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             need_scroll;
        logic             read_ok;
        logic             n_zero;
        logic             scr_done;
        logic             copy_phase;
        logic             sweep_last;
        logic             out_free;
    } t_dp_status;

    function automatic logic [COL_W-1:0] eff_cols(input logic [COL_W-1:0] c);
        logic [COL_W-1:0] e;
        e = c;
        if (c == '0) begin
            e = COL_W'(1);
        end else if (c > COL_W'(MAX_COLUMNS)) begin
            e = COL_W'(MAX_COLUMNS);
        end
        return e;
    endfunction

    function automatic logic [ROW_W-1:0] eff_rows(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] e;
        e = r;
        if (r == '0) begin
            e = ROW_W'(1);
        end else if (r > ROW_W'(MAX_ROWS)) begin
            e = ROW_W'(MAX_ROWS);
        end
        return e;
    endfunction

endpackage

// File: src/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console with a 2000-cell screen store, cursor and
// current attribute; one result word per command word.
// ----------------------------------------------------------------------------
// After reset the block clears the screen store, one cell per cycle, and
// holds o_stall high until the clear is done. Configuration writes wait
// for the clear too, because o_cfg_ready is high only while the block
// idles with no command word offered. The store is a single memory with
// one write and one read port. Put character without a scroll, set
// attribute and unknown commands load their result from the execute state,
// or from the done state while the previous result is still held. Read
// cell adds a wait state for the registered memory read, except for an
// index outside the store. Clear walks the whole store. Scroll by n copies
// each kept cell with a read step and then a write step, and blanks each
// freed cell with one write step. A scroll by zero rows goes from setup
// straight to done. A put character that runs past the last row adds one
// such scroll with n = 1. The next word is accepted as soon as the block is
// back in its idle state, even while the previous result still waits.
module text_console_writer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ctw_pkg::CMD_W-1:0]        i_command,
    input  logic [ctw_pkg::CHAR_W-1:0]       i_value,
    input  logic [ctw_pkg::ROW_W-1:0]        i_scroll_rows,
    input  logic [ctw_pkg::CIDX_W-1:0]       i_cell_index,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ctw_pkg::COL_W-1:0]        o_cursor_col,
    output logic [ctw_pkg::ROW_W-1:0]        o_cursor_row,
    output logic [ctw_pkg::CHAR_W-1:0]       o_cell_char,
    output logic [ctw_pkg::CHAR_W-1:0]       o_cell_attr,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ctw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ctw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    ctw_pkg::t_ctrl_cmd  w_cmd;
    ctw_pkg::t_dp_status w_status;
    ctw_pkg::t_state     w_state;
    logic                w_cfg_we;

    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    ctw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_state     (w_state),
        .o_stall     (o_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    ctw_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_scroll_rows (i_scroll_rows),
        .i_cell_index  (i_cell_index),
        .i_cfg_we      (w_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_cursor_col  (o_cursor_col),
        .o_cursor_row  (o_cursor_row),
        .o_cell_char   (o_cell_char),
        .o_cell_attr   (o_cell_attr)
    );

    // An accepted word always starts its execution on the next cycle.
    a_accept_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (w_state == ctw_pkg::ST_EXEC))
        else $error("accepted word did not enter execution");

    // No word is taken while the store is being swept.
    a_no_accept_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ctw_pkg::ST_INIT || w_state == ctw_pkg::ST_CLR) |-> o_stall)
        else $error("word accepted during store sweep");

    // A result only appears at the end of a command, never from idle or init.
    a_result_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(w_state) == ctw_pkg::ST_EXEC ||
                            $past(w_state) == ctw_pkg::ST_RD_WAIT ||
                            $past(w_state) == ctw_pkg::ST_DONE))
        else $error("result loaded outside a command");

    // A scroll write step is always followed by the next read step.
    a_scroll_pair : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ctw_pkg::ST_SCR_WR) |=> (w_state == ctw_pkg::ST_SCR_RD))
        else $error("scroll copy sequence broken");

endmodule

// File: src/ctw_ram.sv
// ----------------------------------------------------------------------------
// ctw_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ctw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ctw_ctrl.sv
// ----------------------------------------------------------------------------
// ctw_ctrl
// Controller of the text console writer: sequences each command word
// through the datapath and decides when the result is loaded.
// ----------------------------------------------------------------------------
module ctw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ctw_pkg::t_dp_status   i_status,
    output ctw_pkg::t_ctrl_cmd    o_cmd,
    output ctw_pkg::t_state       o_state,
    output logic                  o_stall,
    output logic                  o_cfg_ready
);

    ctw_pkg::t_state r_state;
    ctw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctw_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ctw_pkg::ST_INIT: begin
                if (i_status.sweep_last) begin
                    n_state = ctw_pkg::ST_IDLE;
                end
            end
            ctw_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = ctw_pkg::ST_EXEC;
                end
            end
            ctw_pkg::ST_EXEC: begin
                if (i_status.command == ctw_pkg::CMD_CLEAR) begin
                    n_state = ctw_pkg::ST_CLR;
                end else if (i_status.command == ctw_pkg::CMD_SCROLL ||
                             (i_status.command == ctw_pkg::CMD_PUT &&
                              i_status.need_scroll)) begin
                    n_state = ctw_pkg::ST_SETUP;
                end else if (i_status.command == ctw_pkg::CMD_READ &&
                             i_status.read_ok) begin
                    n_state = ctw_pkg::ST_RD_WAIT;
                end else if (i_status.out_free) begin
                    n_state = ctw_pkg::ST_IDLE;
                end else begin
                    n_state = ctw_pkg::ST_DONE;
                end
            end
            ctw_pkg::ST_CLR: begin
                if (i_status.sweep_last) begin
                    n_state = ctw_pkg::ST_DONE;
                end
            end
            ctw_pkg::ST_SETUP: begin
                n_state = i_status.n_zero ? ctw_pkg::ST_DONE : ctw_pkg::ST_SCR_RD;
            end
            ctw_pkg::ST_SCR_RD: begin
                if (i_status.scr_done) begin
                    n_state = ctw_pkg::ST_DONE;
                end else if (i_status.copy_phase) begin
                    n_state = ctw_pkg::ST_SCR_WR;
                end
            end
            ctw_pkg::ST_SCR_WR: begin
                n_state = ctw_pkg::ST_SCR_RD;
            end
            ctw_pkg::ST_RD_WAIT: begin
                n_state = i_status.out_free ? ctw_pkg::ST_IDLE : ctw_pkg::ST_DONE;
            end
            ctw_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ctw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ctw_pkg::ST_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd.op       = ctw_pkg::OP_NONE;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ctw_pkg::ST_INIT: begin
                o_cmd.op = ctw_pkg::OP_SWEEP;
            end
            ctw_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = ctw_pkg::OP_LATCH;
                end
            end
            ctw_pkg::ST_EXEC: begin
                o_cmd.op = ctw_pkg::OP_EXEC;
                // Commands that finish here load the result if the output register is free.
                if (i_status.command != ctw_pkg::CMD_CLEAR &&
                    i_status.command != ctw_pkg::CMD_SCROLL &&
                    !(i_status.command == ctw_pkg::CMD_PUT && i_status.need_scroll) &&
                    !(i_status.command == ctw_pkg::CMD_READ && i_status.read_ok)) begin
                    o_cmd.load_out = i_status.out_free;
                end
            end
            ctw_pkg::ST_CLR: begin
                o_cmd.op = ctw_pkg::OP_SWEEP;
            end
            ctw_pkg::ST_SETUP: begin
                o_cmd.op = ctw_pkg::OP_SCR_SETUP;
            end
            ctw_pkg::ST_SCR_RD: begin
                o_cmd.op = ctw_pkg::OP_SCR_RD;
            end
            ctw_pkg::ST_SCR_WR: begin
                o_cmd.op = ctw_pkg::OP_SCR_WR;
            end
            ctw_pkg::ST_RD_WAIT: begin
                o_cmd.op       = ctw_pkg::OP_RD_CAP;
                o_cmd.load_out = i_status.out_free;
            end
            ctw_pkg::ST_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd.op = ctw_pkg::OP_NONE;
            end
        endcase
    end

    assign o_state     = r_state;
    assign o_stall     = (r_state != ctw_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == ctw_pkg::ST_IDLE) && !i_valid;

endmodule

// File: src/ctw_dp.sv
// ----------------------------------------------------------------------------
// ctw_dp
// Datapath of the text console writer: screen store, cursor, attribute,
// geometry registers, sweep and scroll pointers, and the result register.
// ----------------------------------------------------------------------------
module ctw_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ctw_pkg::t_ctrl_cmd               i_cmd,
    output ctw_pkg::t_dp_status              o_status,
    input  logic [ctw_pkg::CMD_W-1:0]        i_command,
    input  logic [ctw_pkg::CHAR_W-1:0]       i_value,
    input  logic [ctw_pkg::ROW_W-1:0]        i_scroll_rows,
    input  logic [ctw_pkg::CIDX_W-1:0]       i_cell_index,
    input  logic                             i_cfg_we,
    input  logic [ctw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ctw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [ctw_pkg::COL_W-1:0]        o_cursor_col,
    output logic [ctw_pkg::ROW_W-1:0]        o_cursor_row,
    output logic [ctw_pkg::CHAR_W-1:0]       o_cell_char,
    output logic [ctw_pkg::CHAR_W-1:0]       o_cell_attr
);

    localparam int AW = ctw_pkg::ADDR_W;
    localparam int CW = ctw_pkg::COL_W;
    localparam int RW = ctw_pkg::ROW_W;
    localparam int PW = ctw_pkg::PROD_W;

    logic [ctw_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [ctw_pkg::CHAR_W-1:0] r_value, n_value;
    logic [RW-1:0]              r_nscroll, n_nscroll;
    logic [ctw_pkg::CIDX_W-1:0] r_cell, n_cell;
    logic [CW-1:0]              r_x, n_x;
    logic [RW-1:0]              r_y, n_y;
    logic [ctw_pkg::CHAR_W-1:0] r_attr, n_attr;
    logic [CW-1:0]              r_cols, n_cols;
    logic [RW-1:0]              r_rows, n_rows;
    logic [RW-1:0]              r_n, n_n;
    logic [AW-1:0]              r_off, n_off;
    logic [AW-1:0]              r_total, n_total;
    logic [AW-1:0]              r_dst, n_dst;
    logic [ctw_pkg::CELL_W-1:0] r_rd, n_rd;
    logic                       r_ovalid, n_ovalid;
    logic [CW-1:0]              r_out_col, n_out_col;
    logic [RW-1:0]              r_out_row, n_out_row;
    logic [ctw_pkg::CELL_W-1:0] r_out_cell, n_out_cell;

    logic [CW-1:0]              w_cols;
    logic [RW-1:0]              w_rows;
    logic [CW:0]                w_px;
    logic [RW:0]                w_py;
    logic                       w_put_write;
    logic                       w_need_scroll;
    logic [PW-1:0]              w_put_addr;
    logic [RW-1:0]              w_nsat;
    logic [AW:0]                w_src;
    logic                       w_copy_phase;
    logic                       w_scr_done;
    logic                       w_read_ok;
    logic [CW-1:0]              w_new_cols;
    logic [RW-1:0]              w_new_rows;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ctw_pkg::CELL_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ctw_pkg::CELL_W-1:0] ram_rdata;

    ctw_ram #(
        .WIDTH (ctw_pkg::CELL_W),
        .DEPTH (ctw_pkg::STORE_DEPTH)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_cols = ctw_pkg::eff_cols(r_cols);
    assign w_rows = ctw_pkg::eff_rows(r_rows);

    // Cursor motion of a put-character word, before any scroll.
    always_comb begin
        w_px        = {1'b0, r_x};
        w_py        = {1'b0, r_y};
        w_put_write = 1'b0;
        case (r_value)
            ctw_pkg::CH_TAB: begin
                w_px = ({1'b0, r_x} & ~(CW+1)'(ctw_pkg::TAB_STOP - 1)) +
                       (CW+1)'(ctw_pkg::TAB_STOP);
            end
            ctw_pkg::CH_LF: begin
                w_px = '0;
                w_py = w_py + (RW+1)'(1);
            end
            ctw_pkg::CH_CR: begin
                w_px = '0;
            end
            default: begin
                w_px        = w_px + (CW+1)'(1);
                w_put_write = 1'b1;
            end
        endcase
        if (w_px >= {1'b0, w_cols}) begin
            w_px = '0;
            w_py = w_py + (RW+1)'(1);
        end
    end

    assign w_need_scroll = (w_py >= {1'b0, w_rows});
    assign w_put_addr    = PW'(r_y) * PW'(w_cols) + PW'(r_x);
    assign w_nsat        = (r_nscroll > w_rows) ? w_rows : r_nscroll;
    assign w_src         = {1'b0, r_dst} + {1'b0, r_off};
    assign w_copy_phase  = (w_src < {1'b0, r_total});
    assign w_scr_done    = (r_dst >= r_total);
    assign w_read_ok     = (r_cell < ctw_pkg::CIDX_W'(ctw_pkg::STORE_DEPTH));

    assign w_new_cols = (i_cfg_index == ctw_pkg::CFG_COLUMNS) ?
                        ctw_pkg::eff_cols(CW'(i_cfg_data)) : w_cols;
    assign w_new_rows = (i_cfg_index == ctw_pkg::CFG_ROWS) ?
                        ctw_pkg::eff_rows(RW'(i_cfg_data)) : w_rows;

    always_comb begin
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_nscroll  = r_nscroll;
        n_cell     = r_cell;
        n_x        = r_x;
        n_y        = r_y;
        n_attr     = r_attr;
        n_cols     = r_cols;
        n_rows     = r_rows;
        n_n        = r_n;
        n_off      = r_off;
        n_total    = r_total;
        n_dst      = r_dst;
        n_rd       = r_rd;
        n_ovalid   = r_ovalid;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_cell = r_out_cell;
        ram_we     = 1'b0;
        ram_waddr  = r_dst;
        ram_wdata  = '0;
        ram_raddr  = '0;

        case (i_cmd.op)
            ctw_pkg::OP_LATCH: begin
                n_cmd     = i_command;
                n_value   = i_value;
                n_nscroll = i_scroll_rows;
                n_cell    = i_cell_index;
            end
            ctw_pkg::OP_EXEC: begin
                n_rd = '0;
                case (r_cmd)
                    ctw_pkg::CMD_PUT: begin
                        n_x       = CW'(w_px);
                        n_y       = RW'(w_py);
                        ram_we    = w_put_write;
                        ram_waddr = AW'(w_put_addr);
                        ram_wdata = {r_attr, r_value};
                        if (w_need_scroll) begin
                            n_n = RW'(1);
                        end
                    end
                    ctw_pkg::CMD_CLEAR: begin
                        n_x    = '0;
                        n_y    = '0;
                        n_attr = ctw_pkg::ATTR_DEFAULT;
                        n_dst  = '0;
                    end
                    ctw_pkg::CMD_SET_ATTR: begin
                        n_attr = r_value;
                    end
                    ctw_pkg::CMD_SCROLL: begin
                        n_n = w_nsat;
                    end
                    ctw_pkg::CMD_READ: begin
                        ram_raddr = AW'(r_cell);
                    end
                    default: begin
                        n_rd = '0;
                    end
                endcase
            end
            ctw_pkg::OP_SWEEP: begin
                ram_we = 1'b1;
                n_dst  = r_dst + AW'(1);
            end
            ctw_pkg::OP_SCR_SETUP: begin
                n_off   = AW'(PW'(w_cols) * PW'(r_n));
                n_total = AW'(PW'(w_cols) * PW'(w_rows));
                n_dst   = '0;
                n_y     = (r_y >= r_n) ? (r_y - r_n) : '0;
            end
            ctw_pkg::OP_SCR_RD: begin
                // Rows still inside the area are copied up; the rest are blanked.
                if (!w_scr_done) begin
                    if (w_copy_phase) begin
                        ram_raddr = AW'(w_src);
                    end else begin
                        ram_we = 1'b1;
                        n_dst  = r_dst + AW'(1);
                    end
                end
            end
            ctw_pkg::OP_SCR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_dst     = r_dst + AW'(1);
            end
            ctw_pkg::OP_RD_CAP: begin
                n_rd = ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase

        if (i_cfg_we) begin
            if (i_cfg_index == ctw_pkg::CFG_COLUMNS) begin
                n_cols = CW'(i_cfg_data);
            end else begin
                n_rows = RW'(i_cfg_data);
            end
            if (r_x >= w_new_cols) begin
                n_x = w_new_cols - CW'(1);
            end
            if (r_y >= w_new_rows) begin
                n_y = w_new_rows - RW'(1);
            end
        end

        if (i_cmd.load_out) begin
            n_ovalid   = 1'b1;
            n_out_col  = n_x;
            n_out_row  = n_y;
            n_out_cell = n_rd;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_attr   <= ctw_pkg::ATTR_DEFAULT;
            r_cols   <= CW'(ctw_pkg::MAX_COLUMNS);
            r_rows   <= RW'(ctw_pkg::MAX_ROWS);
            r_dst    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_attr   <= n_attr;
            r_cols   <= n_cols;
            r_rows   <= n_rows;
            r_dst    <= n_dst;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_value    <= n_value;
        r_nscroll  <= n_nscroll;
        r_cell     <= n_cell;
        r_n        <= n_n;
        r_off      <= n_off;
        r_total    <= n_total;
        r_rd       <= n_rd;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_cell <= n_out_cell;
    end

    assign o_status.command     = r_cmd;
    assign o_status.need_scroll = w_need_scroll;
    assign o_status.read_ok     = w_read_ok;
    assign o_status.n_zero      = (r_n == '0);
    assign o_status.scr_done    = w_scr_done;
    assign o_status.copy_phase  = w_copy_phase;
    assign o_status.sweep_last  = (r_dst == AW'(ctw_pkg::STORE_DEPTH - 1));
    assign o_status.out_free    = !r_ovalid || !i_stall;

    assign o_valid      = r_ovalid;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_cell_char  = r_out_cell[ctw_pkg::CHAR_W-1:0];
    assign o_cell_attr  = r_out_cell[ctw_pkg::CELL_W-1:ctw_pkg::CHAR_W];

endmodule

// File: tb/text_console_writer_top_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking bench for the text console writer. A directed table covers
// the control characters, the field extremes, reads outside the store and
// the clear, scroll and attribute commands. Random phases then follow, each
// under its own column and row setting. Every accepted command word updates
// a shadow screen in the bench; results are checked against it or the table.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;

    localparam int IDLE_PCT     = 26;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 14;
    localparam int CALM_PHASE   = 6;
    localparam int BIG_AREA     = 300;

    localparam logic [ctw_pkg::CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [ctw_pkg::CMD_W-1:0] CMD_LAST_UNUSED  = '1;

    typedef struct packed {
        logic [ctw_pkg::CMD_W-1:0]  command;
        logic [ctw_pkg::CHAR_W-1:0] value;
        logic [ctw_pkg::ROW_W-1:0]  scroll_rows;
        logic [ctw_pkg::CIDX_W-1:0] cell_index;
    } t_console_word;

    typedef struct packed {
        logic [ctw_pkg::COL_W-1:0]  col;
        logic [ctw_pkg::ROW_W-1:0]  row;
        logic [ctw_pkg::CHAR_W-1:0] ch;
        logic [ctw_pkg::CHAR_W-1:0] attr;
    } t_console_result;

    typedef struct packed {
        t_console_word   word;
        logic            typed;
        t_console_result res;
    } t_directed_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [ctw_pkg::CMD_W-1:0]      i_command = '0;
    logic [ctw_pkg::CHAR_W-1:0]     i_value = '0;
    logic [ctw_pkg::ROW_W-1:0]      i_scroll_rows = '0;
    logic [ctw_pkg::CIDX_W-1:0]     i_cell_index = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [ctw_pkg::COL_W-1:0]      o_cursor_col;
    logic [ctw_pkg::ROW_W-1:0]      o_cursor_row;
    logic [ctw_pkg::CHAR_W-1:0]     o_cell_char;
    logic [ctw_pkg::CHAR_W-1:0]     o_cell_attr;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ctw_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ctw_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the console state.
    logic [ctw_pkg::CELL_W-1:0] shadow_cells [ctw_pkg::STORE_DEPTH];
    int unsigned                shadow_x;
    int unsigned                shadow_y;
    logic [ctw_pkg::CHAR_W-1:0] shadow_attr;
    int unsigned                shadow_cols;
    int unsigned                shadow_rows;

    t_console_result pending_results [$];
    t_directed_row   directed_rows [$];
    int              errors = 0;
    bit              calm = 1'b0;

    // Raw register values; several exceed the active limits or carry
    // high bits that the row register drops.
    logic [ctw_pkg::CFG_DATA_W-1:0] phase_cols [NUM_PHASES] =
        '{7'd0, 7'd1, 7'd127, 7'd4, 7'd80, 7'd7, 7'd3,
          7'd12, 7'd1, 7'd100, 7'd5, 7'd9, 7'd2, 7'd6};
    logic [ctw_pkg::CFG_DATA_W-1:0] phase_rows [NUM_PHASES] =
        '{7'd0, 7'd31, 7'd1, 7'd2, 7'd127, 7'd5, 7'd67,
          7'd3, 7'd25, 7'd10, 7'd4, 7'd2, 7'd7, 7'd96};

    text_console_writer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_scroll_rows (i_scroll_rows),
        .i_cell_index  (i_cell_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cursor_col  (o_cursor_col),
        .o_cursor_row  (o_cursor_row),
        .o_cell_char   (o_cell_char),
        .o_cell_attr   (o_cell_attr),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned active_cols();
        if (shadow_cols == 0) return 1;
        if (shadow_cols > ctw_pkg::MAX_COLUMNS) return ctw_pkg::MAX_COLUMNS;
        return shadow_cols;
    endfunction

    function automatic int unsigned active_rows();
        if (shadow_rows == 0) return 1;
        if (shadow_rows > ctw_pkg::MAX_ROWS) return ctw_pkg::MAX_ROWS;
        return shadow_rows;
    endfunction

    task automatic clear_shadow();
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        shadow_x    = 0;
        shadow_y    = 0;
        shadow_attr = ctw_pkg::ATTR_DEFAULT;
    endtask

    // Only the active area moves; the freed bottom rows are blanked.
    task automatic scroll_shadow(input int unsigned n);
        int unsigned w;
        int unsigned h;
        int unsigned keep;
        w = active_cols();
        h = active_rows();
        if (n > h) n = h;
        if (n == 0) return;
        keep = w * (h - n);
        for (int unsigned i = 0; i < keep; i++) shadow_cells[i] = shadow_cells[i + w * n];
        for (int unsigned i = keep; i < w * h; i++) shadow_cells[i] = '0;
        shadow_y = (shadow_y >= n) ? shadow_y - n : 0;
    endtask

    task automatic put_into_shadow(input logic [ctw_pkg::CHAR_W-1:0] c);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        w = active_cols();
        h = active_rows();
        if (c == ctw_pkg::CH_TAB) begin
            shadow_x += ctw_pkg::TAB_STOP - (shadow_x % ctw_pkg::TAB_STOP);
        end else if (c == ctw_pkg::CH_LF) begin
            shadow_x = 0;
            shadow_y++;
        end else if (c == ctw_pkg::CH_CR) begin
            shadow_x = 0;
        end else begin
            idx = shadow_y * w + shadow_x;
            if (idx < ctw_pkg::STORE_DEPTH) shadow_cells[idx] = {shadow_attr, c};
            shadow_x++;
        end
        if (shadow_x >= w) begin
            shadow_x = 0;
            shadow_y++;
        end
        if (shadow_y >= h) scroll_shadow(shadow_y - h + 1);
    endtask

    task automatic apply_word(input t_console_word w, output t_console_result r);
        r = '0;
        case (w.command)
            ctw_pkg::CMD_PUT:      put_into_shadow(w.value);
            ctw_pkg::CMD_CLEAR:    clear_shadow();
            ctw_pkg::CMD_SET_ATTR: shadow_attr = w.value;
            ctw_pkg::CMD_SCROLL:   scroll_shadow(32'(w.scroll_rows));
            ctw_pkg::CMD_READ: begin
                if (w.cell_index < ctw_pkg::STORE_DEPTH) begin
                    {r.attr, r.ch} = shadow_cells[w.cell_index];
                end
            end
            default: ;
        endcase
        r.col = shadow_x[ctw_pkg::COL_W-1:0];
        r.row = shadow_y[ctw_pkg::ROW_W-1:0];
    endtask

    // Entered and left at a falling edge; valid stays high into the next
    // call so that back-to-back words need no gap.
    task automatic send_word(input t_console_word w, input logic typed,
                             input t_console_result typed_res);
        t_console_result r;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= w.command;
        i_value       <= w.value;
        i_scroll_rows <= w.scroll_rows;
        i_cell_index  <= w.cell_index;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_word(w, r);
        pending_results.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [ctw_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ctw_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == ctw_pkg::CFG_COLUMNS) shadow_cols = 32'(data);
        else shadow_rows = 32'(data[ctw_pkg::ROW_W-1:0]);
        if (shadow_x >= active_cols()) shadow_x = active_cols() - 1;
        if (shadow_y >= active_rows()) shadow_y = active_rows() - 1;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [ctw_pkg::CMD_W-1:0] cmd,
                           input logic [ctw_pkg::CHAR_W-1:0] val,
                           input logic [ctw_pkg::ROW_W-1:0] nscr,
                           input logic [ctw_pkg::CIDX_W-1:0] idx,
                           input logic typed, input logic [ctw_pkg::COL_W-1:0] col,
                           input logic [ctw_pkg::ROW_W-1:0] row,
                           input logic [ctw_pkg::CHAR_W-1:0] ch,
                           input logic [ctw_pkg::CHAR_W-1:0] attr);
        t_directed_row d;
        d.word  = '{command: cmd, value: val, scroll_rows: nscr, cell_index: idx};
        d.typed = typed;
        d.res   = '{col: col, row: row, ch: ch, attr: attr};
        directed_rows.push_back(d);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_results
        t_console_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no command word waiting for it");
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("cursor_col", 32'(want.col), 32'(o_cursor_col));
                check_field("cursor_row", 32'(want.row), 32'(o_cursor_row));
                check_field("cell_char", 32'(want.ch), 32'(o_cell_char));
                check_field("cell_attr", 32'(want.attr), 32'(o_cell_attr));
            end
        end
    end

    initial begin
        #100_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        t_console_word w;
        int unsigned   pick;
        int unsigned   area;
        int            n_items;

        shadow_cols = ctw_pkg::MAX_COLUMNS;
        shadow_rows = ctw_pkg::MAX_ROWS;
        clear_shadow();

        // Directed table, run at the reset size of 80 by 25.
        add_row(ctw_pkg::CMD_READ, 8'h00, 5'd0, 11'd0, 1, 7'd0, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_READ, 8'hFF, 5'd31, 11'd2047, 1, 7'd0, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_READ, 8'h00, 5'd0, 11'd2000, 1, 7'd0, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_PUT, "A", 5'd0, 11'd0, 1, 7'd1, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_READ, 8'h00, 5'd0, 11'd0, 1, 7'd1, 5'd0, "A",
                ctw_pkg::ATTR_DEFAULT);
        add_row(ctw_pkg::CMD_PUT, ctw_pkg::CH_TAB, 5'd0, 11'd0, 1, 7'd4, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_PUT, 8'hFF, 5'd0, 11'd0, 1, 7'd5, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_PUT, 8'h00, 5'd0, 11'd0, 1, 7'd6, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_PUT, ctw_pkg::CH_CR, 5'd0, 11'd0, 1, 7'd0, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_PUT, ctw_pkg::CH_LF, 5'd0, 11'd0, 1, 7'd0, 5'd1, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_SET_ATTR, 8'hFF, 5'd0, 11'd0, 1, 7'd0, 5'd1, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_PUT, "Z", 5'd31, 11'd2047, 0, '0, '0, '0, '0);
        add_row(ctw_pkg::CMD_READ, 8'h00, 5'd0, 11'd80, 0, '0, '0, '0, '0);
        add_row(ctw_pkg::CMD_SET_ATTR, 8'h00, 5'd0, 11'd0, 0, '0, '0, '0, '0);
        add_row(ctw_pkg::CMD_PUT, "q", 5'd0, 11'd0, 0, '0, '0, '0, '0);
        add_row(ctw_pkg::CMD_SCROLL, 8'hFF, 5'd0, 11'd0, 0, '0, '0, '0, '0);
        add_row(ctw_pkg::CMD_SCROLL, 8'h00, 5'd1, 11'd0, 0, '0, '0, '0, '0);
        add_row(ctw_pkg::CMD_READ, 8'h00, 5'd0, 11'd0, 0, '0, '0, '0, '0);
        add_row(CMD_FIRST_UNUSED, 8'hFF, 5'd31, 11'd2047, 0, '0, '0, '0, '0);
        add_row(CMD_LAST_UNUSED, 8'h55, 5'd3, 11'd1, 0, '0, '0, '0, '0);
        add_row(ctw_pkg::CMD_SCROLL, 8'h00, 5'd31, 11'd0, 0, '0, '0, '0, '0);
        add_row(ctw_pkg::CMD_READ, 8'h00, 5'd0, 11'd1, 0, '0, '0, '0, '0);
        add_row(ctw_pkg::CMD_CLEAR, 8'hFF, 5'd31, 11'd2047, 1, 7'd0, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_PUT, "B", 5'd0, 11'd0, 1, 7'd1, 5'd0, 8'h00, 8'h00);
        add_row(ctw_pkg::CMD_READ, 8'h00, 5'd0, 11'd0, 1, 7'd1, 5'd0, "B",
                ctw_pkg::ATTR_DEFAULT);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);
        end

        // Random phases; the sender drains the block before each new setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_register(ctw_pkg::CFG_COLUMNS, phase_cols[p]);
            write_register(ctw_pkg::CFG_ROWS, phase_rows[p]);
            i_cfg_valid <= 1'b0;
            calm = (p == CALM_PHASE);
            area = active_cols() * active_rows();
            // Scroll cost grows with the area, so big screens get fewer words.
            n_items = (area > BIG_AREA) ? 30 : 60;
            for (int k = 0; k < n_items; k++) begin
                w.command     = ctw_pkg::CMD_PUT;
                w.value       = ctw_pkg::CHAR_W'($urandom_range(255));
                w.scroll_rows = ctw_pkg::ROW_W'($urandom_range(31));
                w.cell_index  = ctw_pkg::CIDX_W'($urandom_range(2047));
                pick = $urandom_range(99);
                if (pick < 55) begin
                    if (pick < 6) w.value = ctw_pkg::CH_TAB;
                    else if (pick < 13) w.value = ctw_pkg::CH_LF;
                    else if (pick < 17) w.value = ctw_pkg::CH_CR;
                end else if (pick < 75) begin
                    w.command = ctw_pkg::CMD_READ;
                    if ($urandom_range(9) < 7) begin
                        w.cell_index = ctw_pkg::CIDX_W'($urandom_range(area - 1));
                    end
                end else if (pick < 83) begin
                    w.command = ctw_pkg::CMD_SET_ATTR;
                end else if (pick < 92) begin
                    w.command = ctw_pkg::CMD_SCROLL;
                    if ($urandom_range(9) < 7) begin
                        w.scroll_rows = ctw_pkg::ROW_W'($urandom_range(active_rows()));
                    end
                end else if (pick < 94) begin
                    w.command = ctw_pkg::CMD_CLEAR;
                end else if (pick < 97) begin
                    w.command = ctw_pkg::CMD_W'($urandom_range(CMD_LAST_UNUSED,
                                                               CMD_FIRST_UNUSED));
                end
                send_word(w, 1'b0, '0);
            end
        end

        calm = 1'b0;
        wait_drained();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
